FILE: rtl/assert_macros.svh
// assertion helper macros shared by the rtl folder
// expects clk_i and rst_ni to be visible where a macro is used

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PQ_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("pq assertion failed");

// next-cycle implication, disabled during reset
`define PQ_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("pq assertion failed");

`endif

FILE: rtl/pq_pkg.sv
// shared constants, command codes and pipeline tag type of the pq encoder
// no dependencies
`timescale 1ns / 1ps

package pq_pkg;

  localparam int SUB_DIM       = 4;
  localparam int NUM_SUBQ      = 8;
  localparam int MAX_CODE_BITS = 8;

  // fixed item field widths
  localparam int ELEM_W  = 16;
  localparam int SUB_W   = 3;
  localparam int CIDX_W  = 8;
  localparam int CODE_W  = 8;
  localparam int CB_W    = 4;
  localparam int IN_ELEMS = (SUB_DIM < 4) ? SUB_DIM : 4;

  // centroid store geometry
  localparam int IDX_W   = MAX_CODE_BITS;
  localparam int SLOTS   = 1 << MAX_CODE_BITS;
  localparam int DEPTH   = NUM_SUBQ * SLOTS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int ROW_W   = SUB_DIM * ELEM_W;

  // distance widths: |diff| <= 2^16 - 1, so its square fits in 32 bits
  localparam int SQ_W    = 2 * ELEM_W;
  localparam int DIST_W  = SQ_W + $clog2(SUB_DIM) + 1;

  localparam logic [CB_W-1:0] CODE_BITS_RST = CB_W'(8);

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_ENCODE = 1'b1
  } pq_cmd_e;

  // travels alongside each centroid read through the lanes and merge
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] idx;
  } pq_tag_t;

endpackage

FILE: rtl/pq_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module pq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pq_lane.sv
// one distance lane: squared difference of one element pair, registered
// depends on pq_pkg
`timescale 1ns / 1ps

module pq_lane
  import pq_pkg::*;
(
  input  logic                     clk_i,
  input  logic signed [ELEM_W-1:0] x_i,
  input  logic signed [ELEM_W-1:0] c_i,
  output logic        [SQ_W-1:0]   sq_o
);

  logic signed [ELEM_W:0]       diff;
  logic signed [2*ELEM_W+1:0]   prod;
  logic        [SQ_W-1:0]       sq_d, sq_q;

  // sign-extended difference, then its square (always fits in SQ_W bits)
  always_comb begin
    diff = {x_i[ELEM_W-1], x_i} - {c_i[ELEM_W-1], c_i};
    prod = diff * diff;
    sq_d = prod[SQ_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
  end

  assign sq_o = sq_q;

endmodule

FILE: rtl/pq_merge.sv
// merge stage: sums the lane squares and keeps the running nearest centroid
// depends on pq_pkg
`timescale 1ns / 1ps

module pq_merge
  import pq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SQ_W-1:0]  sq_i [SUB_DIM],
  input  pq_tag_t          tag_i,
  output logic             done_o,
  output logic [IDX_W-1:0] idx_o
);

  logic [DIST_W-1:0] sum_d, sum_q;
  pq_tag_t           tag_q;
  logic [DIST_W-1:0] best_dist_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic              take;

  // adder tree over the lanes
  always_comb begin
    sum_d = '0;
    for (int e = 0; e < SUB_DIM; e++) begin
      sum_d = sum_d + DIST_W'(sq_i[e]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  // strict less-than keeps the lowest index on ties
  assign take = tag_q.first || (sum_q < best_dist_q);

  always_ff @(posedge clk_i) begin
    if (tag_q.valid && take) begin
      best_dist_q <= sum_q;
      best_idx_q  <= tag_q.idx;
    end
  end

  assign done_o = tag_q.valid && tag_q.last;
  assign idx_o  = take ? tag_q.idx : best_idx_q;

endmodule

FILE: rtl/product_quantizer_encode.sv
// product quantizer encoder: a load item writes one centroid and leaves the encoder idle,
// so loads can follow back to back; an encode item reads 2^n centroids, one per cycle,
// with n = code_bits held to 1..8; its code passes the ram read, lane and merge registers
// into the output register, and the next item is taken only once that code enters the
// output register, later while a stalled code still fills the output register
// async active-low reset clears control and sets code_bits to 8; centroid ram is not cleared
`timescale 1ns / 1ps
`include "assert_macros.svh"

module product_quantizer_encode
  import pq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CB_W-1:0]          cfg_data_i,
  // input item channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     cmd_i,
  input  logic [SUB_W-1:0]         sub_index_i,
  input  logic [CIDX_W-1:0]        centroid_index_i,
  input  logic signed [ELEM_W-1:0] elem_a_i,
  input  logic signed [ELEM_W-1:0] elem_b_i,
  input  logic signed [ELEM_W-1:0] elem_c_i,
  input  logic signed [ELEM_W-1:0] elem_d_i,
  // result item channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [SUB_W-1:0]         code_sub_o,
  output logic [CODE_W-1:0]        code_value_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_HOLD  = 4'b1000
  } state_e;

  state_e                   state_q, state_d;
  logic [CB_W-1:0]          code_bits_q;
  logic [CB_W-1:0]          eff_bits;
  logic [IDX_W-1:0]         last_idx;
  logic                     accept;
  logic                     sub_ok, cidx_ok;
  logic signed [ELEM_W-1:0] elem_in [4];
  logic signed [ELEM_W-1:0] vec_q [SUB_DIM];
  logic [ROW_W-1:0]         wrow;
  logic                     ram_we, ram_re;
  logic [ADDR_W-1:0]        waddr, raddr;
  logic [ROW_W-1:0]         rrow;
  logic [SUB_W-1:0]         sub_q;
  logic [IDX_W-1:0]         last_q, idx_q, res_q;
  pq_tag_t                  tag0, tag1_q, tag2_q;
  logic [SQ_W-1:0]          sq [SUB_DIM];
  logic                     merge_done;
  logic [IDX_W-1:0]         merge_idx;
  logic                     out_valid_q;
  logic [SUB_W-1:0]         code_sub_q;
  logic [CODE_W-1:0]        code_value_q;
  logic                     out_free;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_bits_q <= CODE_BITS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      code_bits_q <= cfg_data_i;
    end
  end

  // clamp code_bits to 1..MAX_CODE_BITS and form the last searched index
  always_comb begin
    if (code_bits_q == '0) begin
      eff_bits = CB_W'(1);
    end else if (code_bits_q > CB_W'(MAX_CODE_BITS)) begin
      eff_bits = CB_W'(MAX_CODE_BITS);
    end else begin
      eff_bits = code_bits_q;
    end
    last_idx = ~({IDX_W{1'b1}} << eff_bits);
  end

  // input decode
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign sub_ok     = {1'b0, sub_index_i} < (SUB_W + 1)'(NUM_SUBQ);
  assign cidx_ok    = {1'b0, centroid_index_i} < (CIDX_W + 1)'(SLOTS);

  assign elem_in[0] = elem_a_i;
  assign elem_in[1] = elem_b_i;
  assign elem_in[2] = elem_c_i;
  assign elem_in[3] = elem_d_i;

  // centroid row: element e sits at bits [16e+15:16e], missing elements are zero
  always_comb begin
    wrow = '0;
    for (int e = 0; e < IN_ELEMS; e++) begin
      wrow[e*ELEM_W +: ELEM_W] = elem_in[e];
    end
  end

  assign ram_we = accept && (cmd_i == CMD_LOAD) && sub_ok && cidx_ok;
  assign waddr  = ADDR_W'({sub_index_i, IDX_W'(centroid_index_i)});
  assign ram_re = (state_q == S_SCAN);
  assign raddr  = ADDR_W'({sub_q, idx_q});

  pq_ram #(
    .WIDTH(ROW_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(wrow),
    .re_i   (ram_re),
    .raddr_i(raddr),
    .rdata_o(rrow)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (cmd_i == CMD_ENCODE)) begin
          state_d = sub_ok ? S_SCAN : S_HOLD;
        end
      end
      S_SCAN: begin
        if (idx_q == last_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (merge_done) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // encode item payload and scan index
  always_ff @(posedge clk_i) begin
    if (accept && (cmd_i == CMD_ENCODE)) begin
      sub_q  <= sub_index_i;
      last_q <= last_idx;
      idx_q  <= '0;
      res_q  <= '0;
      for (int e = 0; e < SUB_DIM; e++) begin
        vec_q[e] <= (e < IN_ELEMS) ? elem_in[e] : '0;
      end
    end else if (state_q == S_SCAN) begin
      idx_q <= idx_q + IDX_W'(1);
    end else if ((state_q == S_DRAIN) && merge_done) begin
      res_q <= merge_idx;
    end
  end

  // tag issued with each read, delayed to line up with ram data and lanes
  always_comb begin
    tag0.valid = ram_re;
    tag0.first = (idx_q == '0);
    tag0.last  = (idx_q == last_q);
    tag0.idx   = idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= tag0;
      tag2_q <= tag1_q;
    end
  end

  // one lane per element
  for (genvar g = 0; g < SUB_DIM; g++) begin : g_lane
    pq_lane u_lane (
      .clk_i(clk_i),
      .x_i  (vec_q[g]),
      .c_i  (rrow[g*ELEM_W +: ELEM_W]),
      .sq_o (sq[g])
    );
  end

  pq_merge u_merge (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .sq_i  (sq),
    .tag_i (tag2_q),
    .done_o(merge_done),
    .idx_o (merge_idx)
  );

  // output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_HOLD) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_HOLD) && out_free) begin
      code_sub_q   <= sub_q;
      code_value_q <= CODE_W'(res_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_sub_o   = code_sub_q;
  assign code_value_o = code_value_q;

  // checks
  `PQ_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state_q))
  `PQ_ASSERT_NOW(a_done_in_drain, merge_done, state_q == S_DRAIN)
  `PQ_ASSERT_NOW(a_write_when_idle, ram_we, state_q == S_IDLE && !ram_re)
  `PQ_ASSERT_NEXT(a_scan_ends, (state_q == S_SCAN) && (idx_q == last_q), state_q == S_DRAIN)

endmodule
